/* design/tts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tts_pkg
// Shared types, segment codes and helpers for the temperature display block.
// -----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned LimitWidth   = 7;
  localparam int unsigned RawWidth     = 16;
  localparam int unsigned SegWidth     = 8;
  localparam logic [LimitWidth-1:0] LimitReset = 7'd75;

  // Segment bytes, bit 0 is the decimal point
  localparam logic [SegWidth-1:0] SegBlank = 8'h00;
  localparam logic [SegWidth-1:0] SegDash  = 8'h02;
  localparam logic [SegWidth-1:0] SegC     = 8'hD8;
  localparam logic [SegWidth-1:0] SegDp    = 8'h01;

  // Positive readings with a high byte above this are out of range
  localparam logic [7:0] MaxHighByte = 8'h04;

  typedef struct packed {
    logic                sensor_present;
    logic [RawWidth-1:0] raw_reading;
  } req_t;

  typedef struct packed {
    logic [SegWidth-1:0] digit0_segments;
    logic [SegWidth-1:0] digit1_segments;
    logic [SegWidth-1:0] digit2_segments;
    logic [SegWidth-1:0] digit3_segments;
    logic                sensor_error;
  } res_t;

  // Decimal digit to segment byte
  function automatic logic [SegWidth-1:0] seg_digit(input logic [3:0] d);
    logic [SegWidth-1:0] s;
    begin
      unique case (d)
        4'd0:    s = 8'hFC;
        4'd1:    s = 8'h24;
        4'd2:    s = 8'hBA;
        4'd3:    s = 8'hAE;
        4'd4:    s = 8'h66;
        4'd5:    s = 8'hCE;
        4'd6:    s = 8'hDE;
        4'd7:    s = 8'hA4;
        4'd8:    s = 8'hFE;
        4'd9:    s = 8'hEE;
        default: s = SegBlank;
      endcase
      return s;
    end
  endfunction

  // Quotient by ten for 8-bit values: (x * 205) >> 11 is exact below 1024
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    begin
      p = 16'(x) * 16'd205;
      return p[15:11];
    end
  endfunction

  // Tenths from the fraction nibble: (nib * 10) / 16
  function automatic logic [3:0] tenths_of(input logic [3:0] nib);
    logic [7:0] p;
    begin
      p = 8'(nib) * 8'd10;
      return p[7:4];
    end
  endfunction

endpackage
`default_nettype wire

/* design/tts_convert.sv */
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tts_convert
// Combinational reading-to-segments conversion between the two registers.
// -----------------------------------------------------------------------------
module tts_convert (
  input  tts_pkg::req_t                         req_i,
  input  logic [tts_pkg::LimitWidth-1:0]        limit_i,
  output tts_pkg::res_t                         res_o
);

  logic [tts_pkg::RawWidth-1:0] mag;
  logic [7:0] neg_whole;
  logic [4:0] neg_div;
  logic [7:0] neg_units;
  logic [3:0] neg_tens;
  logic [3:0] neg_tenths;
  logic [6:0] pos_whole;
  logic [4:0] pos_div;
  logic [7:0] pos_units;
  logic [3:0] pos_tenths;
  logic       pos_range_err;

  always_comb begin
    // negative branch
    mag        = (~req_i.raw_reading) + 16'd1;
    neg_whole  = mag[11:4];
    neg_div    = tts_pkg::div10(neg_whole);
    neg_units  = neg_whole - 8'(neg_div) * 8'd10;
    neg_tens   = {1'b0, neg_div[2:0]};
    neg_tenths = tts_pkg::tenths_of(mag[3:0]);

    // positive branch; whole fits 7 bits once the high byte is checked
    pos_whole     = req_i.raw_reading[10:4];
    pos_div       = tts_pkg::div10({1'b0, pos_whole});
    pos_units     = {1'b0, pos_whole} - 8'(pos_div) * 8'd10;
    pos_tenths    = tts_pkg::tenths_of(req_i.raw_reading[3:0]);
    pos_range_err = (req_i.raw_reading[15:8] > tts_pkg::MaxHighByte) ||
                    (pos_whole > limit_i);

    res_o.digit0_segments = tts_pkg::SegDash;
    res_o.digit1_segments = tts_pkg::SegDash;
    res_o.digit2_segments = tts_pkg::SegDash;
    res_o.digit3_segments = tts_pkg::SegDash;
    res_o.sensor_error    = 1'b1;

    if (!req_i.sensor_present) begin
      res_o.sensor_error = 1'b1;
    end else if (req_i.raw_reading[15]) begin
      res_o.sensor_error    = 1'b0;
      res_o.digit3_segments = tts_pkg::SegC;
      if (neg_tens == 4'd0) begin
        res_o.digit1_segments = tts_pkg::seg_digit(neg_units[3:0]) | tts_pkg::SegDp;
        res_o.digit2_segments = tts_pkg::seg_digit(neg_tenths);
      end else begin
        res_o.digit1_segments = tts_pkg::seg_digit(neg_tens);
        res_o.digit2_segments = tts_pkg::seg_digit(neg_units[3:0]);
      end
    end else if (!pos_range_err) begin
      res_o.sensor_error    = 1'b0;
      res_o.digit0_segments = (pos_div == 5'd0) ? tts_pkg::SegBlank
                                                : tts_pkg::seg_digit({1'b0, pos_div[2:0]});
      res_o.digit1_segments = tts_pkg::seg_digit(pos_units[3:0]) | tts_pkg::SegDp;
      res_o.digit2_segments = tts_pkg::seg_digit(pos_tenths);
      res_o.digit3_segments = tts_pkg::SegC;
    end
  end

endmodule
`default_nettype wire

/* design/temperature_to_seven_segment.sv */
`timescale 1ns / 1ps
`default_nettype none
// A request taken into the input register is converted and then captured in the
//   result register, which raises done_o: one input register, one result register.
// Throughput: one request per cycle; busy_o is never raised.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears the valid flags and loads the limit with 75 degrees.
// -----------------------------------------------------------------------------
// temperature_to_seven_segment
// Converts a raw two's-complement 1/16-degree reading into four segment bytes.
// -----------------------------------------------------------------------------
module temperature_to_seven_segment (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request side
  input  logic                           start_i,
  output logic                           busy_o,
  input  tts_pkg::req_t                  req_i,
  // configuration: upper limit in whole degrees
  input  logic                           cfg_we_i,
  input  logic [tts_pkg::LimitWidth-1:0] cfg_wdata_i,
  // result side
  output logic                           done_o,
  output tts_pkg::res_t                  res_o
);

  // Stage 1: captured request
  logic          req_valid_d, req_valid_q;
  tts_pkg::req_t req_d, req_q;

  // Limit register
  logic [tts_pkg::LimitWidth-1:0] limit_d, limit_q;

  // Stage 2: result register
  logic          res_valid_d, res_valid_q;
  tts_pkg::res_t res_d, res_q;

  // Pure pipeline, nothing ever holds a request back
  assign busy_o = 1'b0;

  assign req_valid_d = start_i && !busy_o;
  assign req_d       = req_i;
  assign limit_d     = cfg_we_i ? cfg_wdata_i : limit_q;
  assign res_valid_d = req_valid_q;

  // Conversion logic sits between the two registers
  tts_convert u_convert (
    .req_i   (req_q),
    .limit_i (limit_q),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      limit_q     <= tts_pkg::LimitReset;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
      limit_q     <= limit_d;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (req_valid_d) begin
      req_q <= req_d;
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = res_valid_q;
  assign res_o  = res_q;

  // Every accepted request yields exactly one result after both registers
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("accepted request produced no result");

  // No result without an earlier accepted request that passed both registers
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without request");

  // Error flag means four dashes
  a_err_dashes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.sensor_error) |->
      (res_o.digit0_segments == tts_pkg::SegDash) &&
      (res_o.digit1_segments == tts_pkg::SegDash) &&
      (res_o.digit2_segments == tts_pkg::SegDash) &&
      (res_o.digit3_segments == tts_pkg::SegDash))
    else $error("error flag without dash display");

  // A valid reading always ends in the degree C symbol
  a_good_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.sensor_error) |-> (res_o.digit3_segments == tts_pkg::SegC))
    else $error("good reading without C symbol");

endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Regression for the temperature display converter: directed corner readings,
// an upper-limit sweep and a long random run, each request checked against an
// in-bench model of the four segment bytes and the error flag.
// -----------------------------------------------------------------------------
module testbench;

  // A request passes the input and result registers before done_o shows it
  localparam int PipeDepth     = 2;
  localparam int TailCycles    = 8;
  localparam int CycleLimit    = 400000;
  localparam int MaxReported   = 10;
  localparam int RandomItems   = 1900;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           busy_o;
  tts_pkg::req_t                  req_i = '0;
  logic                           cfg_we_i = 1'b0;
  logic [tts_pkg::LimitWidth-1:0] cfg_wdata_i = '0;
  logic                           done_o;
  tts_pkg::res_t                  res_o;

  temperature_to_seven_segment dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the limit register, tracked by the config task
  logic [tts_pkg::LimitWidth-1:0] limit_shadow = tts_pkg::LimitReset;

  // Displays still owed by the block, oldest first
  tts_pkg::res_t expected_displays[$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // When set, requests go out back to back with no idle cycles
  bit back_to_back = 1'b0;

  // ---------------------------------------------------------------------------
  // Display model
  // ---------------------------------------------------------------------------

  // Decimal digit to segment byte, bit 0 is the decimal point
  function automatic logic [tts_pkg::SegWidth-1:0] glyph_of(input int d);
    case (d)
      0: return 8'hFC;
      1: return 8'h24;
      2: return 8'hBA;
      3: return 8'hAE;
      4: return 8'h66;
      5: return 8'hCE;
      6: return 8'hDE;
      7: return 8'hA4;
      8: return 8'hFE;
      9: return 8'hEE;
      default: return tts_pkg::SegBlank;
    endcase
  endfunction

  function automatic tts_pkg::res_t predict_display(
    input tts_pkg::req_t                  r,
    input logic [tts_pkg::LimitWidth-1:0] limit
  );
    tts_pkg::res_t d;
    logic [15:0]   mag;
    logic [7:0]    whole;
    int            tenths;
    int            tens;
    int            units;
    // Four dashes with the error flag is the default answer
    d = '{tts_pkg::SegDash, tts_pkg::SegDash, tts_pkg::SegDash, tts_pkg::SegDash, 1'b1};
    if (!r.sensor_present) begin
      return d;
    end
    if (r.raw_reading[15]) begin
      // Below zero: only bits 11..4 of the magnitude count as whole degrees,
      // and the tens digit wraps at eight
      mag    = ~r.raw_reading + 16'd1;
      whole  = mag[11:4];
      tenths = (int'(mag[3:0]) * 10) / 16;
      tens   = (int'(whole) / 10) % 8;
      units  = int'(whole) % 10;
      d.sensor_error    = 1'b0;
      d.digit0_segments = tts_pkg::SegDash;
      d.digit3_segments = tts_pkg::SegC;
      if (tens == 0) begin
        d.digit1_segments = glyph_of(units) | tts_pkg::SegDp;
        d.digit2_segments = glyph_of(tenths);
      end else begin
        d.digit1_segments = glyph_of(tens);
        d.digit2_segments = glyph_of(units);
      end
      return d;
    end
    // Positive: out of range above the high-byte bound or the limit
    if (r.raw_reading[15:8] > tts_pkg::MaxHighByte) begin
      return d;
    end
    whole = r.raw_reading[11:4];
    if (whole > {1'b0, limit}) begin
      return d;
    end
    tenths = (int'(r.raw_reading[3:0]) * 10) / 16;
    tens   = int'(whole) / 10;
    units  = int'(whole) % 10;
    d.digit0_segments = (tens == 0) ? tts_pkg::SegBlank : glyph_of(tens % 8);
    d.digit1_segments = glyph_of(units) | tts_pkg::SegDp;
    d.digit2_segments = glyph_of(tenths);
    d.digit3_segments = tts_pkg::SegC;
    d.sensor_error    = 1'b0;
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: done_o marks a one-cycle result, no backpressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tts_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (expected_displays.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("[%0t] unexpected result %h", $realtime, res_o);
        end
      end else begin
        want = expected_displays.pop_front();
        if (res_o.digit0_segments !== want.digit0_segments ||
            res_o.digit1_segments !== want.digit1_segments ||
            res_o.digit2_segments !== want.digit2_segments ||
            res_o.digit3_segments !== want.digit3_segments ||
            res_o.sensor_error    !== want.sensor_error) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("[%0t] mismatch: expected %h %h %h %h err %b, got %h %h %h %h err %b",
                     $realtime, want.digit0_segments, want.digit1_segments,
                     want.digit2_segments, want.digit3_segments, want.sensor_error,
                     res_o.digit0_segments, res_o.digit1_segments,
                     res_o.digit2_segments, res_o.digit3_segments, res_o.sensor_error);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("temperature_to_seven_segment regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving helpers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (back_to_back || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hold start low for the requested idle time; req_i carries junk meanwhile
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      req_i   <= tts_pkg::req_t'($urandom);
    end
  endtask

  // Present one request, wait for the handshake, log the expected display, then idle for a random gap.
  // start_i is left high when the gap is zero, so the next request can follow back to back.
  task automatic send_request(input logic present,
                              input logic [tts_pkg::RawWidth-1:0] raw);
    tts_pkg::req_t r;
    r.sensor_present = present;
    r.raw_reading    = raw;
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    expected_displays.push_back(predict_display(r, limit_shadow));
    idle_for(pick_gap());
  endtask

  // Lower start and wait until every owed display has come out
  task automatic drain();
    idle_for(1);
    while (expected_displays.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 1) @(posedge clk_i);
  endtask

  // Limit writes only happen with the pipe empty
  task automatic set_upper_limit(input logic [tts_pkg::LimitWidth-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= tts_pkg::LimitWidth'($urandom);
    limit_shadow = value;
  endtask

  // Reading of whole.nib degrees, positive side
  function automatic logic [tts_pkg::RawWidth-1:0] reading_of(input int whole,
                                                              input int nib);
    return tts_pkg::RawWidth'((whole << 4) | (nib & 15));
  endfunction

  // Random reading biased toward the interesting regions
  function automatic logic [tts_pkg::RawWidth-1:0] pick_reading();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return tts_pkg::RawWidth'($urandom_range(0, 16'h04FF));
    if (roll < 4) return reading_of(int'(limit_shadow) + $urandom_range(0, 2) - 1,
                                    $urandom_range(0, 15));
    if (roll < 7) return tts_pkg::RawWidth'(-$urandom_range(1, 16'h0FFF));
    if (roll < 8) return tts_pkg::RawWidth'($urandom_range(16'h8000, 16'hFFFF));
    return tts_pkg::RawWidth'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner readings under the reset limit of 75 degrees
  task automatic test_corner_readings();
    send_request(1'b0, 16'h0000);   // sensor missing
    send_request(1'b0, 16'hFFFF);
    send_request(1'b1, 16'h0000);   // 0.0, tens blank
    for (int nib = 1; nib < 16; nib += 2) begin
      send_request(1'b1, reading_of(9, nib));   // tenths truncation
    end
    send_request(1'b1, reading_of(10, 0));
    send_request(1'b1, reading_of(75, 15));   // at the limit
    send_request(1'b1, reading_of(76, 0));    // just above the limit
    send_request(1'b1, 16'h04FF);
    send_request(1'b1, 16'h0500);             // high byte above bound
    send_request(1'b1, 16'h7FFF);
    send_request(1'b1, 16'hFFFF);             // -1/16: -0.0C
    send_request(1'b1, 16'hFF60);             // -10.0: tens shown
    send_request(1'b1, 16'hFF91);             // -6.x: units with point
    send_request(1'b1, 16'h8000);             // magnitude wraps to whole 0
    send_request(1'b1, 16'hF060);             // whole 250: tens wraps mod 8
    send_request(1'b1, 16'hF000);             // bit 12 of magnitude dropped
  endtask

  // Sweep of the limit register: extremes and a few values in between
  task automatic test_limit_sweep();
    logic [tts_pkg::LimitWidth-1:0] limits[$];
    limits = '{7'd0, 7'd79, 7'd1, 7'd64, 7'd42, 7'd9, 7'd10};
    repeat (3) limits.push_back(tts_pkg::LimitWidth'($urandom_range(0, 79)));
    foreach (limits[i]) begin
      set_upper_limit(limits[i]);
      for (int w = int'(limits[i]) - 1; w <= int'(limits[i]) + 1; w++) begin
        if (w >= 0) send_request(1'b1, reading_of(w, $urandom_range(0, 15)));
      end
      send_request(1'b1, 16'h04FF);
      send_request(1'b1, tts_pkg::RawWidth'(-$urandom_range(1, 16'h0FFF)));
      send_request(1'b1, tts_pkg::RawWidth'($urandom_range(0, 16'h04FF)));
    end
  endtask

  // Long random run, limit reprogrammed now and then, bursts without gaps
  task automatic test_random_readings();
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      if (n % 400 == 399) begin
        back_to_back = 1'b0;
        set_upper_limit(tts_pkg::LimitWidth'($urandom_range(0, 79)));
      end
      send_request($urandom_range(0, 15) != 0, pick_reading());
    end
    back_to_back = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_readings();
    test_limit_sweep();
    set_upper_limit(tts_pkg::LimitReset);
    test_random_readings();

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("temperature_to_seven_segment regression: pass");
    end else begin
      $display("temperature_to_seven_segment regression: fail");
    end
    $finish;
  end

endmodule
